[design/lsw_pkg.sv]
// ----------------------------------------------------------------------------
// Link supervision watchdog package
// Shared types, register indexes, reset values and state codes for the
// link supervision watchdog.
// ----------------------------------------------------------------------------
package lsw_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgIdxGrace    = 2'd0;
  localparam logic [1:0] CfgIdxTimeout  = 2'd1;
  localparam logic [1:0] CfgIdxRecovery = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] GraceRst    = 16'd1000;
  localparam logic [15:0] TimeoutRst  = 16'd500;
  localparam logic [7:0]  RecoveryRst = 8'd3;

  // Link state codes as reported on the result stream.
  localparam logic [1:0] LinkWait    = 2'd0;
  localparam logic [1:0] LinkOnline  = 2'd1;
  localparam logic [1:0] LinkTimeout = 2'd2;

  // Command codes of an input transfer.
  localparam logic CmdFrame = 1'b0;
  localparam logic CmdCheck = 1'b1;

  // Internal link mode, one-hot.
  typedef enum logic [2:0] {
    ModeWait    = 3'b001,
    ModeOnline  = 3'b010,
    ModeTimeout = 3'b100
  } mode_e;

  // Live configuration.
  typedef struct packed {
    logic [15:0] grace;
    logic [15:0] timeout;
    logic [7:0]  recovery;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       frame_seen;
    logic       link_online;
    logic       comm_timeout;
    logic [1:0] link_state;
  } result_t;

  // Map the one-hot mode onto the reported state code.
  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] code;
    case (m)
      ModeWait:    code = LinkWait;
      ModeOnline:  code = LinkOnline;
      ModeTimeout: code = LinkTimeout;
      default:     code = LinkWait;
    endcase
    return code;
  endfunction

endpackage

[design/lsw_cfg.sv]
// ----------------------------------------------------------------------------
// Link supervision watchdog configuration registers
// Holds grace time, timeout window and recovery count, written through a
// plain indexed write port.
// ----------------------------------------------------------------------------
module lsw_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output lsw_pkg::cfg_t       cfg_o
);

  lsw_pkg::cfg_t cfg_d, cfg_q;

  // Decode the register index; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lsw_pkg::CfgIdxGrace:    cfg_d.grace    = cfg_data_i;
        lsw_pkg::CfgIdxTimeout:  cfg_d.timeout  = cfg_data_i;
        lsw_pkg::CfgIdxRecovery: cfg_d.recovery = cfg_data_i[7:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grace    <= lsw_pkg::GraceRst;
      cfg_q.timeout  <= lsw_pkg::TimeoutRst;
      cfg_q.recovery <= lsw_pkg::RecoveryRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/lsw_engine.sv]
// ----------------------------------------------------------------------------
// Link supervision watchdog engine
// Supervision state and the combinational update for one frame or check.
// ----------------------------------------------------------------------------
module lsw_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              command_i,
  input  logic [31:0]       now_i,
  input  lsw_pkg::cfg_t     cfg_i,
  output lsw_pkg::result_t  res_o
);

  lsw_pkg::mode_e mode_d, mode_q;
  logic [31:0] last_d, last_q;
  logic [31:0] total_d, total_q;
  logic [31:0] checked_d, checked_q;
  logic [7:0]  good_d, good_q;
  logic        started_d, started_q;
  logic [31:0] start_d, start_q;
  logic        tflag_d, tflag_q;
  logic        oflag_d, oflag_q;
  logic        seen_d, seen_q;

  logic [31:0] total_inc;
  logic [31:0] start_eff;
  logic [31:0] checked_eff;
  logic [31:0] elapsed;
  logic [31:0] since_start;
  logic [31:0] delta;
  logic [8:0]  good_sum;
  logic [7:0]  good_acc;
  logic        grace_over;
  logic        window_over;

  // Shared arithmetic for the step.
  always_comb begin
    total_inc   = total_q + 32'd1;
    start_eff   = started_q ? start_q : last_q;
    checked_eff = started_q ? checked_q : total_q;
    elapsed     = now_i - last_q;
    since_start = now_i - start_eff;
    grace_over  = since_start > {16'd0, cfg_i.grace};
    window_over = elapsed > {16'd0, cfg_i.timeout};
    delta       = total_q - checked_eff;
    good_sum    = {1'b0, good_q} + {1'b0, delta[7:0]};
    if (delta >= {24'd0, cfg_i.recovery}) begin
      good_acc = cfg_i.recovery;
    end else if (good_sum >= {1'b0, cfg_i.recovery}) begin
      good_acc = cfg_i.recovery;
    end else begin
      good_acc = good_sum[7:0];
    end
  end

  // Next-state logic for a frame or a check.
  always_comb begin
    mode_d    = mode_q;
    last_d    = last_q;
    total_d   = total_q;
    checked_d = checked_q;
    good_d    = good_q;
    started_d = started_q;
    start_d   = start_q;
    tflag_d   = tflag_q;
    oflag_d   = oflag_q;
    seen_d    = seen_q;
    if (command_i == lsw_pkg::CmdFrame) begin
      last_d  = now_i;
      seen_d  = 1'b1;
      total_d = total_inc;
      if (mode_q == lsw_pkg::ModeWait) begin
        mode_d    = lsw_pkg::ModeOnline;
        oflag_d   = 1'b1;
        tflag_d   = 1'b0;
        good_d    = 8'd0;
        checked_d = total_inc;
      end
    end else begin
      // The first check latches the start time and the checked count.
      started_d = 1'b1;
      start_d   = start_eff;
      checked_d = checked_eff;
      case (mode_q)
        lsw_pkg::ModeWait: begin
          oflag_d = 1'b0;
          if (grace_over) begin
            mode_d    = lsw_pkg::ModeTimeout;
            tflag_d   = 1'b1;
            good_d    = 8'd0;
            checked_d = total_q;
          end else begin
            tflag_d = 1'b0;
          end
        end
        lsw_pkg::ModeOnline: begin
          if (window_over) begin
            mode_d    = lsw_pkg::ModeTimeout;
            tflag_d   = 1'b1;
            oflag_d   = 1'b0;
            good_d    = 8'd0;
            checked_d = total_q;
          end else begin
            tflag_d = 1'b0;
            oflag_d = 1'b1;
          end
        end
        default: begin
          // Timed out: a stale link clears the accumulation, otherwise new
          // frames add up toward the recovery count.
          tflag_d = 1'b1;
          oflag_d = 1'b0;
          if (window_over) begin
            good_d    = 8'd0;
            checked_d = total_q;
          end else begin
            if (total_q != checked_eff) begin
              checked_d = total_q;
              good_d    = good_acc;
            end
            if (good_d >= cfg_i.recovery) begin
              mode_d  = lsw_pkg::ModeOnline;
              tflag_d = 1'b0;
              oflag_d = 1'b1;
              good_d  = 8'd0;
            end
          end
        end
      endcase
    end
  end

  // State registers, updated once per processed transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lsw_pkg::ModeWait;
      last_q    <= 32'd0;
      total_q   <= 32'd0;
      checked_q <= 32'd0;
      good_q    <= 8'd0;
      started_q <= 1'b0;
      start_q   <= 32'd0;
      tflag_q   <= 1'b0;
      oflag_q   <= 1'b0;
      seen_q    <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      last_q    <= last_d;
      total_q   <= total_d;
      checked_q <= checked_d;
      good_q    <= good_d;
      started_q <= started_d;
      start_q   <= start_d;
      tflag_q   <= tflag_d;
      oflag_q   <= oflag_d;
      seen_q    <= seen_d;
    end
  end

  // Result reflects the state after the step.
  assign res_o.link_state   = lsw_pkg::mode_code(mode_d);
  assign res_o.comm_timeout = tflag_d;
  assign res_o.link_online  = oflag_d;
  assign res_o.frame_seen   = seen_d;

  // The held flags always agree with the mode.
  a_flags_match_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tflag_q == (mode_q == lsw_pkg::ModeTimeout)) &&
    (oflag_q == (mode_q == lsw_pkg::ModeOnline)))
    else $error("lsw: flags disagree with mode");

  // A seen frame always takes the link out of the waiting mode.
  a_seen_not_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (mode_q != lsw_pkg::ModeWait))
    else $error("lsw: frame seen but still waiting");

  // The accumulation is only live while timed out.
  a_good_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != lsw_pkg::ModeTimeout) |-> (good_q == 8'd0))
    else $error("lsw: recovery accumulation outside timeout");

  // Once a frame has been seen, the flag never falls again.
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(seen_q) |-> seen_q)
    else $error("lsw: frame seen flag fell");

endmodule

[design/link_supervision_watchdog.sv]
// ----------------------------------------------------------------------------
// Link supervision watchdog
// Heartbeat timeout watchdog with recovery for a feedback link.
// ----------------------------------------------------------------------------
// Each input transfer is a frame event (tuser 0) or a supervision check
// (tuser 1) stamped with the millisecond time in tdata, and produces exactly
// one result transfer carrying the link state after that event. The block
// takes one transfer every clock cycle while the result stream is not
// stalled. An accepted event is held in the input register while the state
// update settles, and the result register is written once the result slot
// is free, from where the result is taken. The combinational state update
// sets the rate. The output register lets a new transfer enter while a
// result still waits. Configuration writes take effect on the next cycle
// and are meant to be made while no transfer is in flight.
module link_supervision_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] now_ms
  input  logic        s_axis_tuser_i,   // [0] command
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [1:0] link_state, [2] comm_timeout,
                                        // [3] link_online, [4] frame_seen
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic             in_valid_d, in_valid_q;
  logic             in_cmd_q;
  logic [31:0]      in_now_q;
  logic             out_valid_d, out_valid_q;
  lsw_pkg::result_t out_res_q;
  lsw_pkg::result_t step_res;
  lsw_pkg::cfg_t    cfg;
  logic             advance;
  logic             fire;
  logic             in_xfer;

  // Handshake: the input register moves on whenever the result slot frees.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_cmd_q <= s_axis_tuser_i;
      in_now_q <= s_axis_tdata_i;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  lsw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lsw_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .command_i (in_cmd_q),
    .now_i     (in_now_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q.frame_seen, out_res_q.link_online,
                            out_res_q.comm_timeout, out_res_q.link_state};

endmodule
